@@ sv/gdw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_pkg
// Types, constants and small lookup functions for the Gregorian day number
// and weekday core.
// ----------------------------------------------------------------------------
package gdw_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned DN_W     = 22;
    localparam int unsigned WD_W     = 3;

    // year / 100 by reciprocal: exact for every 14-bit year
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned PROD_W       = 27;
    localparam int unsigned QY_W         = 8;
    localparam int unsigned CENT_W       = 7;

    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9999;
    localparam logic [YEAR_W-1:0]   DEF_YM       = 14'd1999;
    localparam logic [MONTH_W-1:0]  DEF_MM       = 4'd13;
    localparam logic [DAY_W-1:0]    DEF_DAY      = 5'd1;
    localparam logic [CENT_W-1:0]   DEF_CENT     = 7'd19;
    localparam logic [CENT_W-1:0]   DEF_YOC      = 7'd99;
    localparam logic [DN_W-1:0]     DEF_DAY_NUM  = 22'd730425;
    localparam logic [WD_W-1:0]     DEF_WEEKDAY  = 3'd6;
    localparam logic [DN_W-1:0]     MIN_DAY_NUM  = 22'd306;

    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]   in_year;
        logic [MONTH_W-1:0]  in_month;
        logic [DAY_W-1:0]    in_day;
        logic [HOUR_W-1:0]   in_hour;
        logic [MINUTE_W-1:0] in_minute;
        logic [SECOND_W-1:0] in_second;
    } t_fields;

    // checked date in march-based form, split into century and year of century
    typedef struct packed {
        logic                date_valid;
        logic [YEAR_W-1:0]   ym;
        logic [MONTH_W-1:0]  mm;
        logic [DAY_W-1:0]    day;
        logic [CENT_W-1:0]   cent;
        logic [CENT_W-1:0]   yoc;
    } t_march;

    typedef struct packed {
        logic                date_valid;
        logic [DN_W-1:0]     day_number;
        logic [WD_W-1:0]     weekday;
    } t_result;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (153*mm - 457) / 5 for march-based months 3..14
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [8:0] off;
        case (mm)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd13:   off = 9'd306;
            4'd14:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // 13*(mm+1)/5 for march-based months 3..14
    function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] mm);
        logic [5:0] t;
        case (mm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // x mod 7 by summing octal digits, since 8 is 1 mod 7
    function automatic logic [2:0] mod7_10(input logic [9:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [2:0] r;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
        return r;
    endfunction

endpackage

@@ sv/gdw_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_req_if
// Request channel: one date and time per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdw_req_if;
    logic        valid;
    logic        ready;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;

    modport source (
        output valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
        input  ready
    );

    modport sink (
        input  valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
        output ready
    );
endinterface

@@ sv/gdw_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_rsp_if
// Result channel: valid flag, day number and weekday, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdw_rsp_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [21:0] day_number;
    logic [2:0]  weekday;

    modport source (
        output valid, date_valid, day_number, weekday,
        input  ready
    );

    modport sink (
        input  valid, date_valid, day_number, weekday,
        output ready
    );
endinterface

@@ sv/gregorian_date_day_number_weekday_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_day_number_weekday_core
// Checks a Gregorian date and time and returns the absolute day number and
// the weekday (0 Sunday).
//
// i_req carries one request: year, month, day, hour, minute, second. o_rsp
// returns one result per request, in order: date_valid, day_number, weekday.
// An invalid request (bad year, month, day or time of day) yields the values
// for 2000-01-01 with date_valid low.
// Four register stages: input, year/100, checked march-based date, result.
// A request is registered in each of those stages in turn before its result appears on o_rsp.
// Throughput is one request per cycle while o_rsp takes results; the year/100
// reciprocal multiply and the day number sum each have a stage of their own.
// Each stage moves when the stage after it is empty or moving, so i_req
// keeps taking requests into empty stages while o_rsp is stalled, and a
// held result stays stable until taken.
// Reset clears every stage's valid bit; no result is pending after reset.
// ----------------------------------------------------------------------------
module gregorian_date_day_number_weekday_core
    import gdw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    gdw_req_if.sink      i_req,
    gdw_rsp_if.source    o_rsp
);

    logic              r_s1_v, r_s2_v, r_s3_v, r_out_v;
    t_fields           r_s1, r_s2;
    logic [QY_W-1:0]   r_s2_qy;
    t_march            r_s3;
    t_result           r_out;

    logic              rdy_out, rdy3, rdy2, rdy1;
    t_fields           n_s1;
    logic [PROD_W-1:0] prod_q;
    logic [QY_W-1:0]   n_s2_qy;
    t_march            n_s3;
    t_result           n_out;

    assign rdy_out = !r_out_v || o_rsp.ready;
    assign rdy3    = !r_s3_v  || rdy_out;
    assign rdy2    = !r_s2_v  || rdy3;
    assign rdy1    = !r_s1_v  || rdy2;

    assign i_req.ready = rdy1;

    assign n_s1.in_year   = i_req.in_year;
    assign n_s1.in_month  = i_req.in_month;
    assign n_s1.in_day    = i_req.in_day;
    assign n_s1.in_hour   = i_req.in_hour;
    assign n_s1.in_minute = i_req.in_minute;
    assign n_s1.in_second = i_req.in_second;

    // year / 100 by reciprocal multiply
    assign prod_q  = PROD_W'(r_s1.in_year) * PROD_W'(DIV100_MUL);
    assign n_s2_qy = prod_q[PROD_W-1:DIV100_SHIFT];

    gdw_check u_check (
        .i_fields (r_s2),
        .i_qy     (r_s2_qy),
        .o_march  (n_s3)
    );

    gdw_calc u_calc (
        .i_march  (r_s3),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= i_req.valid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (rdy_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_req.valid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_s1_v) begin
            r_s2    <= r_s1;
            r_s2_qy <= n_s2_qy;
        end
        if (rdy3 && r_s2_v) begin
            r_s3 <= n_s3;
        end
        if (rdy_out && r_s3_v) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.date_valid = r_out.date_valid;
    assign o_rsp.day_number = r_out.day_number;
    assign o_rsp.weekday    = r_out.weekday;

`ifndef ASSERT_OFF
    a_default_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.date_valid)
            |-> (o_rsp.day_number == DEF_DAY_NUM && o_rsp.weekday == DEF_WEEKDAY))
        else $error("substituted date does not give 2000-01-01 results");

    a_day_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.day_number >= MIN_DAY_NUM && o_rsp.weekday <= 3'd6))
        else $error("day number or weekday out of range");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && rdy_out) |=> o_rsp.valid)
        else $error("checked date lost on its way to the result register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v && r_s3_v && r_out_v && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while the pipeline is full and stalled");
`endif

endmodule

@@ sv/gdw_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_check
// Validates a date and time and converts it to march-based year and month,
// with the year split into century and year of century.
// ----------------------------------------------------------------------------
module gdw_check
    import gdw_pkg::*;
(
    input  t_fields           i_fields,
    input  logic [QY_W-1:0]   i_qy,
    output t_march            o_march
);

    logic [14:0]          prod100;
    logic [YEAR_W-1:0]    rem_w;
    logic [CENT_W-1:0]    rem;
    logic                 leap;
    logic                 ok;
    logic                 early;

    assign prod100 = 15'(i_qy) * 15'd100;
    assign rem_w   = i_fields.in_year - prod100[YEAR_W-1:0];
    assign rem     = rem_w[CENT_W-1:0];

    assign leap = ((i_fields.in_year[1:0] == 2'd0) && (rem != 7'd0))
               || ((rem == 7'd0) && (i_qy[1:0] == 2'd0));

    always_comb begin
        ok = (i_fields.in_year != '0) && (i_fields.in_year <= YEAR_MAX)
          && (i_fields.in_month inside {[4'd1:4'd12]})
          && (i_fields.in_day != '0)
          && (i_fields.in_day <= month_len(i_fields.in_month, leap))
          && (i_fields.in_hour <= 5'd23)
          && (i_fields.in_minute <= 6'd59)
          && (i_fields.in_second <= 6'd59);
    end

    assign early = (i_fields.in_month <= MONTH_FEB);

    always_comb begin
        o_march.date_valid = ok;
        if (!ok) begin
            o_march.ym   = DEF_YM;
            o_march.mm   = DEF_MM;
            o_march.day  = DEF_DAY;
            o_march.cent = DEF_CENT;
            o_march.yoc  = DEF_YOC;
        end else if (early) begin
            // january and february count with the previous year
            o_march.ym  = i_fields.in_year - 14'd1;
            o_march.mm  = i_fields.in_month + 4'd12;
            o_march.day = i_fields.in_day;
            if (rem == 7'd0) begin
                o_march.cent = CENT_W'(i_qy - 8'd1);
                o_march.yoc  = 7'd99;
            end else begin
                o_march.cent = i_qy[CENT_W-1:0];
                o_march.yoc  = rem - 7'd1;
            end
        end else begin
            o_march.ym   = i_fields.in_year;
            o_march.mm   = i_fields.in_month;
            o_march.day  = i_fields.in_day;
            o_march.cent = i_qy[CENT_W-1:0];
            o_march.yoc  = rem;
        end
    end

endmodule

@@ sv/gdw_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_calc
// Absolute day number and Zeller weekday of a march-based date.
// ----------------------------------------------------------------------------
module gdw_calc
    import gdw_pkg::*;
(
    input  t_march   i_march,
    output t_result  o_result
);

    logic [DN_W-1:0] dn;
    logic [9:0]      zsum;
    logic [2:0]      z;

    assign dn = DN_W'(i_march.ym) * 22'd365
              + DN_W'(i_march.ym >> 2)
              - DN_W'(i_march.cent)
              + DN_W'(i_march.cent >> 2)
              + DN_W'(month_offset(i_march.mm))
              + DN_W'(i_march.day)
              - 22'd1;

    assign zsum = 10'(i_march.day)
                + 10'(zeller_month(i_march.mm))
                + 10'(i_march.yoc)
                + 10'(i_march.yoc >> 2)
                + 10'(i_march.cent >> 2)
                + 10'(i_march.cent) * 10'd5;

    assign z = mod7_10(zsum);

    // zeller gives 0 for saturday; shift so sunday is 0
    assign o_result.date_valid = i_march.date_valid;
    assign o_result.day_number = dn;
    assign o_result.weekday    = (z == 3'd0) ? 3'd6 : z - 3'd1;

endmodule
